// ----- sv/sensitive_data_pattern_matcher_core_defines.svh -----
// Assertion macros shared by the pattern matcher modules.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef SENSITIVE_DATA_PATTERN_MATCHER_CORE_DEFINES_SVH
`define SENSITIVE_DATA_PATTERN_MATCHER_CORE_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define SDPM_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define SDPM_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define SDPM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/sdpm_pkg.sv -----
// Shared types, constants and sizes of the pattern matcher.
// Used by every module of the block; depends on nothing else.
package sdpm_pkg;

    localparam int PATTERN_DEPTH = 64;
    localparam int ADDR_W        = $clog2(PATTERN_DEPTH);
    localparam int CUR_W         = $clog2(PATTERN_DEPTH + 1);
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic ACTION_LOAD = 1'b0;
    localparam logic ACTION_DATA = 1'b1;

    typedef enum logic [2:0] {
        KIND_LITERAL   = 3'd0,
        KIND_DIGIT     = 3'd1,
        KIND_NONDIGIT  = 3'd2,
        KIND_ALNUM     = 3'd3,
        KIND_NONALNUM  = 3'd4,
        KIND_LETTER    = 3'd5,
        KIND_NONLETTER = 3'd6,
        KIND_BOUNDARY  = 3'd7
    } t_token_kind;

    typedef struct packed {
        logic        action;
        logic [5:0]  token_slot;
        logic [2:0]  token_kind;
        logic [7:0]  token_literal;
        logic        token_optional;
        logic [7:0]  data_byte;
        logic [15:0] byte_position;
        logic        last_byte;
    } t_in_item;

    typedef struct packed {
        logic        match_found;
        logic [16:0] end_position;
    } t_out_item;

    typedef struct packed {
        logic        optional;
        logic [7:0]  literal;
        t_token_kind kind;
    } t_token;

    // One queued command: a table load or a classified data byte.
    typedef struct packed {
        logic        is_load;
        logic        slot_ok;
        logic [ADDR_W-1:0] slot;
        t_token      token;
        logic [7:0]  data_byte;
        logic        is_digit;
        logic        is_letter;
        logic [15:0] byte_position;
        logic        last_byte;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_LOOK
    } t_back_state;

endpackage

// ----- sv/sdpm_front.sv -----
// Front end: takes input transfers, classifies the data byte and packs a queue command.
// Depends on sdpm_pkg.
module sdpm_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  sdpm_pkg::t_in_item i_in_item,
    input  logic              i_queue_full,
    output logic              o_push,
    output sdpm_pkg::t_cmd    o_cmd
);

    logic dg;
    logic lt;

    always_comb begin
        dg = (i_in_item.data_byte >= 8'h30) && (i_in_item.data_byte <= 8'h39);
        lt = ((i_in_item.data_byte >= 8'h41) && (i_in_item.data_byte <= 8'h5A)) ||
             ((i_in_item.data_byte >= 8'h61) && (i_in_item.data_byte <= 8'h7A));
    end

    assign o_in_stall = i_queue_full;
    assign o_push     = i_in_valid && !i_queue_full;

    always_comb begin
        o_cmd                = '0;
        o_cmd.is_load        = (i_in_item.action == sdpm_pkg::ACTION_LOAD);
        o_cmd.slot_ok        = (int'(i_in_item.token_slot) < sdpm_pkg::PATTERN_DEPTH);
        o_cmd.slot           = sdpm_pkg::ADDR_W'(i_in_item.token_slot);
        o_cmd.token.optional = i_in_item.token_optional;
        o_cmd.token.literal  = i_in_item.token_literal;
        o_cmd.token.kind     = sdpm_pkg::t_token_kind'(i_in_item.token_kind);
        o_cmd.data_byte      = i_in_item.data_byte;
        o_cmd.is_digit       = dg;
        o_cmd.is_letter      = lt;
        o_cmd.byte_position  = i_in_item.byte_position;
        o_cmd.last_byte      = i_in_item.last_byte;
    end

    `include "sensitive_data_pattern_matcher_core_defines.svh"

    `SDPM_ASSERT_IMPLIES(a_front_no_push_full, i_queue_full, !o_push, "push into a full queue")

endmodule

// ----- sv/sdpm_queue.sv -----
// Short command queue between the front end and the token sequencer.
// Depends on sdpm_pkg.
module sdpm_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sdpm_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output sdpm_pkg::t_cmd o_cmd
);

    sdpm_pkg::t_cmd r_entry [sdpm_pkg::QUEUE_DEPTH];
    logic [sdpm_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [sdpm_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [sdpm_pkg::QCNT_W-1:0] r_count;
    logic [sdpm_pkg::QPTR_W-1:0] n_wr_ptr;
    logic [sdpm_pkg::QPTR_W-1:0] n_rd_ptr;
    logic [sdpm_pkg::QCNT_W-1:0] n_count;
    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == sdpm_pkg::QCNT_W'(sdpm_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_entry[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            if (r_wr_ptr == sdpm_pkg::QPTR_W'(sdpm_pkg::QUEUE_DEPTH - 1)) begin
                n_wr_ptr = '0;
            end else begin
                n_wr_ptr = r_wr_ptr + sdpm_pkg::QPTR_W'(1);
            end
        end
        if (do_pop) begin
            if (r_rd_ptr == sdpm_pkg::QPTR_W'(sdpm_pkg::QUEUE_DEPTH - 1)) begin
                n_rd_ptr = '0;
            end else begin
                n_rd_ptr = r_rd_ptr + sdpm_pkg::QPTR_W'(1);
            end
        end
        if (do_push && !do_pop) begin
            n_count = r_count + sdpm_pkg::QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - sdpm_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

    `include "sensitive_data_pattern_matcher_core_defines.svh"

    `SDPM_ASSERT_ALWAYS(a_queue_bound,
        r_count <= sdpm_pkg::QCNT_W'(sdpm_pkg::QUEUE_DEPTH), "queue count overflow")
    `SDPM_ASSERT_NEXT(a_queue_grow, do_push && !do_pop,
        r_count == $past(r_count) + sdpm_pkg::QCNT_W'(1), "queue count did not grow")

endmodule

// ----- sv/sdpm_back.sv -----
// Token sequencer: holds the token table, steps through tokens per data byte and
// registers the result. Depends on sdpm_pkg.
module sdpm_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  sdpm_pkg::t_cmd     i_cmd,
    output logic               o_cmd_pop,
    input  logic [6:0]         i_pattern_length,
    output logic               o_out_valid,
    output sdpm_pkg::t_out_item o_out_item,
    input  logic               i_out_stall
);

    sdpm_pkg::t_token r_table [sdpm_pkg::PATTERN_DEPTH];
    sdpm_pkg::t_token r_token_rd;

    sdpm_pkg::t_back_state r_state;
    sdpm_pkg::t_back_state n_state;
    logic [sdpm_pkg::CUR_W-1:0] r_cursor;
    logic [sdpm_pkg::CUR_W-1:0] n_cursor;
    logic r_decided;
    logic n_decided;
    logic [7:0]  r_byte;
    logic        r_digit;
    logic        r_letter;
    logic [15:0] r_pos;
    logic        r_last;
    logic        r_out_valid;
    sdpm_pkg::t_out_item r_out_item;

    logic [sdpm_pkg::CUR_W-1:0]  act_len;
    logic [sdpm_pkg::CUR_W-1:0]  cur_inc;
    logic [sdpm_pkg::ADDR_W-1:0] rd_addr;
    logic        rd_en;
    logic        wr_en;
    logic        load_byte;
    logic        hit;
    logic        out_free;
    logic        out_load;
    logic        want;
    logic        res;
    logic [16:0] endp;
    logic        ev_exhausted;
    logic        ev_skip;
    logic        ev_optmiss;
    logic        ev_final;
    logic        ev_look;

    always_comb begin
        if (int'(i_pattern_length) > sdpm_pkg::PATTERN_DEPTH) begin
            act_len = sdpm_pkg::CUR_W'(sdpm_pkg::PATTERN_DEPTH);
        end else begin
            act_len = sdpm_pkg::CUR_W'(i_pattern_length);
        end
    end

    assign cur_inc  = r_cursor + sdpm_pkg::CUR_W'(1);
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        unique case (r_token_rd.kind)
            sdpm_pkg::KIND_LITERAL:   hit = (r_token_rd.literal == r_byte);
            sdpm_pkg::KIND_DIGIT:     hit = r_digit;
            sdpm_pkg::KIND_NONDIGIT:  hit = !r_digit;
            sdpm_pkg::KIND_ALNUM:     hit = r_digit || r_letter;
            sdpm_pkg::KIND_NONALNUM:  hit = !(r_digit || r_letter);
            sdpm_pkg::KIND_LETTER:    hit = r_letter;
            sdpm_pkg::KIND_NONLETTER: hit = !r_letter;
            sdpm_pkg::KIND_BOUNDARY:  hit = !r_digit;
        endcase
    end

    // Decode of one token step. At offset zero a boundary token that meets a digit
    // is passed over while another token follows it.
    always_comb begin
        ev_exhausted = (r_cursor >= act_len);
        ev_skip      = !ev_exhausted && (r_pos == 16'd0) &&
                       (r_token_rd.kind == sdpm_pkg::KIND_BOUNDARY) && r_digit &&
                       (cur_inc < act_len);
        ev_optmiss   = !ev_exhausted && !ev_skip && r_token_rd.optional && !hit;
        ev_final     = !ev_exhausted && !ev_skip && !ev_optmiss &&
                       (!hit || (cur_inc >= act_len));
        ev_look      = !ev_exhausted && !ev_skip && !ev_optmiss && !ev_final && r_last;
    end

    always_comb begin
        want = 1'b0;
        res  = 1'b0;
        endp = {1'b0, r_pos} + 17'd1;
        unique case (r_state)
            sdpm_pkg::ST_IDLE: begin
                want = 1'b0;
            end
            sdpm_pkg::ST_EVAL: begin
                if (ev_exhausted) begin
                    want = 1'b1;
                    res  = 1'b1;
                    endp = {1'b0, r_pos};
                end else if (ev_final) begin
                    want = 1'b1;
                    res  = hit;
                end
            end
            sdpm_pkg::ST_LOOK: begin
                want = 1'b1;
                res  = (r_token_rd.kind == sdpm_pkg::KIND_BOUNDARY);
            end
            default: begin
                want = 1'b0;
            end
        endcase
    end

    assign out_load = want && out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sdpm_pkg::ST_IDLE: begin
                if (i_cmd_valid && !i_cmd.is_load && !r_decided) begin
                    n_state = sdpm_pkg::ST_EVAL;
                end
            end
            sdpm_pkg::ST_EVAL: begin
                if (want) begin
                    n_state = out_free ? sdpm_pkg::ST_IDLE : sdpm_pkg::ST_EVAL;
                end else if (ev_skip || ev_optmiss) begin
                    n_state = sdpm_pkg::ST_EVAL;
                end else if (ev_look) begin
                    n_state = sdpm_pkg::ST_LOOK;
                end else begin
                    n_state = sdpm_pkg::ST_IDLE;
                end
            end
            sdpm_pkg::ST_LOOK: begin
                if (out_free) begin
                    n_state = sdpm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sdpm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_cursor  = r_cursor;
        n_decided = r_decided;
        o_cmd_pop = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = sdpm_pkg::ADDR_W'(r_cursor);
        wr_en     = 1'b0;
        load_byte = 1'b0;
        unique case (r_state)
            sdpm_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.is_load) begin
                        wr_en = i_cmd.slot_ok;
                    end else if (r_decided) begin
                        if (i_cmd.last_byte) begin
                            n_cursor  = '0;
                            n_decided = 1'b0;
                        end
                    end else begin
                        load_byte = 1'b1;
                        rd_en     = 1'b1;
                    end
                end
            end
            sdpm_pkg::ST_EVAL: begin
                if (ev_skip || ev_optmiss || ev_look) begin
                    n_cursor = cur_inc;
                    rd_en    = 1'b1;
                    rd_addr  = sdpm_pkg::ADDR_W'(cur_inc);
                end else if (!ev_exhausted && (out_free || !ev_final)) begin
                    n_cursor = cur_inc;
                end
            end
            sdpm_pkg::ST_LOOK: begin
                n_cursor = r_cursor;
            end
            default: begin
                n_cursor = r_cursor;
            end
        endcase
        // A delivered result rearms on the last byte and otherwise locks out the buffer.
        if (out_load) begin
            if (r_last) begin
                n_cursor  = '0;
                n_decided = 1'b0;
            end else begin
                n_decided = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sdpm_pkg::ST_IDLE;
            r_cursor    <= '0;
            r_decided   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cursor  <= n_cursor;
            r_decided <= n_decided;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_byte) begin
            r_byte   <= i_cmd.data_byte;
            r_digit  <= i_cmd.is_digit;
            r_letter <= i_cmd.is_letter;
            r_pos    <= i_cmd.byte_position;
            r_last   <= i_cmd.last_byte;
        end
        if (out_load) begin
            r_out_item.match_found  <= res;
            r_out_item.end_position <= endp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_table[i_cmd.slot] <= i_cmd.token;
        end
        if (rd_en) begin
            r_token_rd <= r_table[rd_addr];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `include "sensitive_data_pattern_matcher_core_defines.svh"

    `SDPM_ASSERT_ALWAYS(a_cursor_bound,
        r_cursor <= sdpm_pkg::CUR_W'(sdpm_pkg::PATTERN_DEPTH), "cursor beyond table")
    `SDPM_ASSERT_IMPLIES(a_pop_in_idle, o_cmd_pop, r_state == sdpm_pkg::ST_IDLE,
        "queue popped while busy")
    `SDPM_ASSERT_NEXT(a_result_locks, out_load && !r_last, r_decided,
        "result did not lock out the buffer")

endmodule

// ----- sv/sensitive_data_pattern_matcher_core.sv -----
// Anchored token-pattern matcher: front end, command queue and token sequencer.
// Path: a data byte passes the queue entry, the byte and token registers and the result register.
// Sequencing: a load or a byte after a decision needs only the idle step; a data byte also needs
// an evaluation step, one more per passed-over optional or boundary token and one for the look-ahead
// on the last byte, set by the single table read port; an output stall holds the sequencer in place.
// Reset clears the control state and pattern length; the token table holds nothing until loaded.
module sensitive_data_pattern_matcher_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  sdpm_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output sdpm_pkg::t_out_item o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [6:0]          i_cfg_data
);

    logic [6:0] r_pattern_length;
    logic       push;
    logic       queue_full;
    logic       queue_valid;
    logic       queue_pop;
    sdpm_pkg::t_cmd front_cmd;
    sdpm_pkg::t_cmd queue_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_length <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_pattern_length <= i_cfg_data;
        end
    end

    sdpm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_cmd        (front_cmd)
    );

    sdpm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_valid (queue_valid),
        .o_cmd   (queue_cmd)
    );

    sdpm_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_valid      (queue_valid),
        .i_cmd            (queue_cmd),
        .o_cmd_pop        (queue_pop),
        .i_pattern_length (r_pattern_length),
        .o_out_valid      (o_out_valid),
        .o_out_item       (o_out_item),
        .i_out_stall      (i_out_stall)
    );

endmodule
